// ===== rtl/lota_pkg.sv =====
// ----------------------------------------------------------------------------
// lota_pkg: shared types and constants for the LoRa time-on-air core
// Field widths, mode codes, branch codes and the sideband records that ride
// alongside the divider cell chains.
// ----------------------------------------------------------------------------
package lota_pkg;

   localparam int SF_W   = 4;
   localparam int BW_W   = 21;
   localparam int CR_W   = 3;
   localparam int MODE_W = 2;
   localparam int PRE_W  = 16;
   localparam int PAY_W  = 8;
   localparam int AIR_W  = 50;
   localparam int QTR_W  = 20;
   localparam int DATA_W = 12;

   // symbol-count divider: numerators below 2^15, divisors up to 48
   localparam int SDIV_NUM_W = 15;
   localparam int SDIV_DEN_W = 6;

   localparam logic [BW_W-1:0] BW_MAX_HZ  = 21'd1625000;
   localparam logic [17:0]     QTR_SCALE  = 18'd250000;
   localparam logic [SF_W-1:0] SF_MIN     = 4'd5;
   localparam logic [SF_W-1:0] SF_MAX     = 4'd12;
   localparam logic [SF_W-1:0] SF_LDRO_ON = 4'd11;
   localparam logic [SF_W-1:0] SF_FS_ON   = 4'd6;
   localparam logic [CR_W-1:0] CR_LI_MIN  = 3'd5;
   localparam logic [CR_W-1:0] CR_MAX     = 3'd7;

   localparam logic [MODE_W-1:0] MODE_OFF  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ON   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_AUTO = 2'd2;
   localparam logic [MODE_W-1:0] MODE_BAD  = 2'd3;

   typedef enum logic [2:0] {
      BR_NORMAL   = 3'b001,
      BR_LI_HDR   = 3'b010,
      BR_LI_FIXED = 3'b100
   } branch_type;

   typedef struct packed {
      logic             invalid;
      logic             ldro;
      logic             fs;
      logic             li;
      branch_type       branch;
      logic [CR_W-1:0]  cr;
      logic [PRE_W-1:0] pre;
      logic [SF_W-1:0]  sf;
      logic [BW_W-1:0]  bw;
   } sdiv_side_type;

   typedef struct packed {
      logic             invalid;
      logic             ldro;
      logic             fs;
      logic             li;
      logic [QTR_W-1:0] quarters;
   } ldiv_side_type;

endpackage

// ===== rtl/lota_div_cell.sv =====
// ----------------------------------------------------------------------------
// lota_div_cell: one restoring-division cell
// Resolves one quotient bit per beat while en is high and hands remainder,
// partial word, divisor and sideband to the next cell.
// ----------------------------------------------------------------------------
module lota_div_cell #(
   parameter int NUM_W  = 15,
   parameter int DEN_W  = 6,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [DEN_W-1:0]  in_rem,
   input  logic [NUM_W-1:0]  in_word,
   input  logic [DEN_W-1:0]  in_div,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [DEN_W-1:0]  out_rem,
   output logic [NUM_W-1:0]  out_word,
   output logic [DEN_W-1:0]  out_div,
   output logic [SIDE_W-1:0] out_side
);
   logic              valid_ff;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [NUM_W-1:0]  word_ff, word_in;
   logic [DEN_W-1:0]  div_ff;
   logic [SIDE_W-1:0] side_ff;
   logic [DEN_W:0]    shifted, diff;
   logic              ge;

   // word shifts numerator bits out at the top and quotient bits in at the bottom
   always_comb begin
      shifted = {in_rem, in_word[NUM_W-1]};
      diff    = shifted - {1'b0, in_div};
      ge      = (shifted >= {1'b0, in_div});
      rem_in  = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      word_in = {in_word[NUM_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         word_ff <= word_in;
         div_ff  <= in_div;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_word  = word_ff;
   assign out_div   = div_ff;
   assign out_side  = side_ff;
endmodule

// ===== rtl/lota_div_chain.sv =====
// ----------------------------------------------------------------------------
// lota_div_chain: pipelined divider built from a row of division cells
// NUM_W cells, one quotient bit each; a division may enter on every en beat.
// ----------------------------------------------------------------------------
module lota_div_chain #(
   parameter int NUM_W  = 15,
   parameter int DEN_W  = 6,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_div,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [NUM_W-1:0]  out_quot,
   output logic [SIDE_W-1:0] out_side
);
   logic              v   [NUM_W+1];
   logic [DEN_W-1:0]  rem [NUM_W+1];
   logic [NUM_W-1:0]  wrd [NUM_W+1];
   logic [DEN_W-1:0]  dv  [NUM_W+1];
   logic [SIDE_W-1:0] sd  [NUM_W+1];

   assign v[0]   = in_valid;
   assign rem[0] = '0;
   assign wrd[0] = in_num;
   assign dv[0]  = in_div;
   assign sd[0]  = in_side;

   for (genvar i = 0; i < NUM_W; i++) begin : g_cell
      lota_div_cell #(
         .NUM_W  (NUM_W),
         .DEN_W  (DEN_W),
         .SIDE_W (SIDE_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (v[i]),
         .in_rem    (rem[i]),
         .in_word   (wrd[i]),
         .in_div    (dv[i]),
         .in_side   (sd[i]),
         .out_valid (v[i+1]),
         .out_rem   (rem[i+1]),
         .out_word  (wrd[i+1]),
         .out_div   (dv[i+1]),
         .out_side  (sd[i+1])
      );
   end

   assign out_valid = v[NUM_W];
   assign out_quot  = wrd[NUM_W];
   assign out_side  = sd[NUM_W];
endmodule

// ===== rtl/lota_front.sv =====
// ----------------------------------------------------------------------------
// lota_front: query check, mode resolution and divider operand setup
// Picks the symbol-count branch and forms both ceiling-division operands.
// ----------------------------------------------------------------------------
module lota_front (
   input  logic [lota_pkg::SF_W-1:0]        spreading_factor,
   input  logic [lota_pkg::BW_W-1:0]        bandwidth_hz,
   input  logic [lota_pkg::CR_W-1:0]        code_rate,
   input  logic [lota_pkg::MODE_W-1:0]      ldro_mode,
   input  logic [lota_pkg::MODE_W-1:0]      fine_sync_mode,
   input  logic [lota_pkg::MODE_W-1:0]      interleave_mode,
   input  logic [lota_pkg::PRE_W-1:0]       preamble_symbols,
   input  logic                             explicit_header,
   input  logic                             crc_present,
   input  logic [lota_pkg::PAY_W-1:0]       payload_bytes,
   output logic [lota_pkg::SDIV_NUM_W-1:0]  num_a,
   output logic [lota_pkg::SDIV_DEN_W-1:0]  div_a,
   output logic [lota_pkg::SDIV_NUM_W-1:0]  num_b,
   output logic [lota_pkg::SDIV_DEN_W-1:0]  div_b,
   output logic                             neg_b,
   output lota_pkg::sdiv_side_type          side
);
   import lota_pkg::*;

   logic               invalid, fs, li, ldro;
   logic [8:0]         bytes;
   logic signed [13:0] hbits, h2, b8, p8, pbits, pbits_h, a_fix;
   logic [3:0]         bps, st;
   logic [3:0]         d;
   logic [SDIV_DEN_W-1:0] div4;
   logic [13:0]        t2bd;

   always_comb begin
      invalid = (spreading_factor < SF_MIN) || (spreading_factor > SF_MAX) ||
                (bandwidth_hz == '0) || (bandwidth_hz > BW_MAX_HZ) ||
                (code_rate == '0) || (ldro_mode == MODE_BAD) ||
                (fine_sync_mode == MODE_BAD) || (interleave_mode == MODE_BAD);

      fs   = (fine_sync_mode == MODE_AUTO) ? (spreading_factor <= SF_FS_ON)
                                           : fine_sync_mode[0];
      li   = (interleave_mode == MODE_AUTO) ? (code_rate >= CR_LI_MIN)
                                            : interleave_mode[0];
      ldro = (ldro_mode == MODE_AUTO) ? (spreading_factor >= SF_LDRO_ON)
                                      : ldro_mode[0];

      bytes = {1'b0, payload_bytes} + {7'd0, crc_present, 1'b0};
      b8    = $signed({2'b00, bytes, 3'b000});
      p8    = $signed({3'b000, payload_bytes, 3'b000});
      hbits = $signed({8'd0, spreading_factor, 2'b00}) + $signed({10'd0, fs, 3'b000})
              - 14'sd8 - (explicit_header ? 14'sd20 : 14'sd0);
      bps   = spreading_factor - {2'b00, ldro, 1'b0};
      st    = spreading_factor - 4'd2 + {2'b00, fs, 1'b0};
      d     = {1'b0, code_rate} + ((code_rate == CR_MAX) ? 4'd1 : 4'd0);
      div4  = {bps, 2'b00};

      // normal branch payload bits, clamped at zero
      pbits = b8 - hbits;
      if (pbits < 0) begin
         pbits = '0;
      end
      // interleaved explicit-header branch clamps header bits first
      h2 = hbits;
      if ((hbits < b8) && (hbits > p8)) begin
         h2 = p8;
      end
      pbits_h = b8 - h2;
      if (pbits_h < 0) begin
         pbits_h = '0;
      end

      t2bd  = (14'(bytes) * 14'(d)) << 1;
      a_fix = $signed(t2bd) - $signed({7'd0, st, 3'b000});

      num_b = '0;
      div_b = {2'b00, bps};
      neg_b = 1'b0;
      if (!li) begin
         side.branch = BR_NORMAL;
         num_a = SDIV_NUM_W'(pbits[12:0]) + SDIV_NUM_W'(div4) - 15'd1;
         div_a = div4;
      end else if (explicit_header) begin
         side.branch = BR_LI_HDR;
         num_a = SDIV_NUM_W'(pbits_h[12:0]) * SDIV_NUM_W'(d) + SDIV_NUM_W'(div4) - 15'd1;
         div_a = div4;
      end else begin
         side.branch = BR_LI_FIXED;
         num_a = SDIV_NUM_W'(t2bd) + SDIV_NUM_W'(st) - 15'd1;
         div_a = {2'b00, st};
         // signed ceiling: floor of the magnitude when negative
         if (a_fix < 0) begin
            neg_b = 1'b1;
            num_b = SDIV_NUM_W'(-a_fix);
         end else begin
            num_b = SDIV_NUM_W'(a_fix) + SDIV_NUM_W'(bps) - 15'd1;
         end
      end

      side.invalid = invalid;
      side.ldro    = ldro;
      side.fs      = fs;
      side.li      = li;
      side.cr      = code_rate;
      side.pre     = preamble_symbols;
      side.sf      = spreading_factor;
      side.bw      = bandwidth_hz;
   end
endmodule

// ===== rtl/lota_time_on_air_core.sv =====
// Pipeline from an accepted req beat to its rsp beat: 15 symbol-count division
// cells, symbol assembly, scale multiply, 50 airtime division cells.
// Throughput: one query per cycle; the whole pipeline advances whenever the
// output register is empty or its beat is taken.
// Reset: synchronous, active high; clears all valid bits, payload is left alone.
// ----------------------------------------------------------------------------
// lora_time_on_air_core: LoRa packet airtime calculator
// Resolves modes, counts symbols in quarter-symbol units and divides the
// scaled count by the bandwidth with round-to-nearest.
// ----------------------------------------------------------------------------
module lora_time_on_air_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [lota_pkg::SF_W-1:0]     req_spreading_factor,
   input  logic [lota_pkg::BW_W-1:0]     req_bandwidth_hz,
   input  logic [lota_pkg::CR_W-1:0]     req_code_rate,
   input  logic [lota_pkg::MODE_W-1:0]   req_ldro_mode,
   input  logic [lota_pkg::MODE_W-1:0]   req_fine_sync_mode,
   input  logic [lota_pkg::MODE_W-1:0]   req_interleave_mode,
   input  logic [lota_pkg::PRE_W-1:0]    req_preamble_symbols,
   input  logic                          req_explicit_header,
   input  logic                          req_crc_present,
   input  logic [lota_pkg::PAY_W-1:0]    req_payload_bytes,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lota_pkg::AIR_W-1:0]    rsp_airtime_us,
   output logic [lota_pkg::QTR_W-1:0]    rsp_total_quarter_symbols,
   output logic                          rsp_ldro_used,
   output logic                          rsp_fine_sync_used,
   output logic                          rsp_interleave_used,
   output logic                          rsp_invalid
);
   import lota_pkg::*;

   localparam int PROD_W = QTR_W + 18;

   logic en;

   logic [SDIV_NUM_W-1:0] num_a, num_b, quot_a, quot_b;
   logic [SDIV_DEN_W-1:0] div_a, div_b;
   logic                  neg_b, neg_b_out;
   sdiv_side_type         side_f, side_a;
   logic                  va, vb;

   logic [DATA_W-1:0]     data;
   logic [QTR_W-1:0]      quarters;

   logic                  p1_valid_ff, p2_valid_ff;
   ldiv_side_type         p1_side_ff, p2_side_ff;
   logic [SF_W-1:0]       p1_sf_ff, p2_sf_ff;
   logic [BW_W-1:0]       p1_bw_ff, p2_bw_ff;
   logic [PROD_W-1:0]     p2_prod_ff;
   ldiv_side_type         p1_side_in;

   logic [AIR_W-1:0]      big_num, big_quot;
   ldiv_side_type         side_out;

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   lota_front u_front (
      .spreading_factor (req_spreading_factor),
      .bandwidth_hz     (req_bandwidth_hz),
      .code_rate        (req_code_rate),
      .ldro_mode        (req_ldro_mode),
      .fine_sync_mode   (req_fine_sync_mode),
      .interleave_mode  (req_interleave_mode),
      .preamble_symbols (req_preamble_symbols),
      .explicit_header  (req_explicit_header),
      .crc_present      (req_crc_present),
      .payload_bytes    (req_payload_bytes),
      .num_a            (num_a),
      .div_a            (div_a),
      .num_b            (num_b),
      .div_b            (div_b),
      .neg_b            (neg_b),
      .side             (side_f)
   );

   lota_div_chain #(
      .NUM_W  (SDIV_NUM_W),
      .DEN_W  (SDIV_DEN_W),
      .SIDE_W ($bits(sdiv_side_type))
   ) u_div_a (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_num    (num_a),
      .in_div    (div_a),
      .in_side   (side_f),
      .out_valid (va),
      .out_quot  (quot_a),
      .out_side  (side_a)
   );

   lota_div_chain #(
      .NUM_W  (SDIV_NUM_W),
      .DEN_W  (SDIV_DEN_W),
      .SIDE_W (1)
   ) u_div_b (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_num    (num_b),
      .in_div    (div_b),
      .in_side   (neg_b),
      .out_valid (vb),
      .out_quot  (quot_b),
      .out_side  (neg_b_out)
   );

   // data symbols, then total in quarter symbols
   always_comb begin
      case (side_a.branch)
         BR_NORMAL: begin
            data = DATA_W'(8) + DATA_W'(quot_a[DATA_W-1:0] * ({1'b0, side_a.cr} + 4'd4));
         end
         BR_LI_HDR: begin
            data = DATA_W'(8) + quot_a[DATA_W-1:0];
         end
         BR_LI_FIXED: begin
            if (quot_a < SDIV_NUM_W'(8)) begin
               data = quot_a[DATA_W-1:0];
            end else if (neg_b_out) begin
               data = DATA_W'(8) - quot_b[DATA_W-1:0];
            end else begin
               data = DATA_W'(8) + quot_b[DATA_W-1:0];
            end
         end
         default: begin
            data = '0;
         end
      endcase
      quarters = {2'b00, side_a.pre, 2'b00} + QTR_W'(17) + QTR_W'({side_a.fs, 3'b000})
                 + QTR_W'({data, 2'b00});
      p1_side_in.invalid  = side_a.invalid;
      p1_side_in.ldro     = side_a.ldro;
      p1_side_in.fs       = side_a.fs;
      p1_side_in.li       = side_a.li;
      p1_side_in.quarters = quarters;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff <= va && vb;
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_side_ff <= p1_side_in;
         p1_sf_ff   <= side_a.sf;
         p1_bw_ff   <= side_a.bw;
         p2_side_ff <= p1_side_ff;
         p2_sf_ff   <= p1_sf_ff;
         p2_bw_ff   <= p1_bw_ff;
         p2_prod_ff <= PROD_W'(p1_side_ff.quarters) * PROD_W'(QTR_SCALE);
      end
   end

   // half the bandwidth added up front gives round-half-up
   assign big_num = (AIR_W'(p2_prod_ff) << p2_sf_ff) + AIR_W'(p2_bw_ff >> 1);

   lota_div_chain #(
      .NUM_W  (AIR_W),
      .DEN_W  (BW_W),
      .SIDE_W ($bits(ldiv_side_type))
   ) u_div_air (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p2_valid_ff),
      .in_num    (big_num),
      .in_div    (p2_bw_ff),
      .in_side   (p2_side_ff),
      .out_valid (rsp_valid),
      .out_quot  (big_quot),
      .out_side  (side_out)
   );

   assign rsp_invalid               = side_out.invalid;
   assign rsp_airtime_us            = side_out.invalid ? '0 : big_quot;
   assign rsp_total_quarter_symbols = side_out.invalid ? '0 : side_out.quarters;
   assign rsp_ldro_used             = side_out.ldro && !side_out.invalid;
   assign rsp_fine_sync_used        = side_out.fs && !side_out.invalid;
   assign rsp_interleave_used       = side_out.li && !side_out.invalid;
endmodule

// ===== tb/lora_time_on_air_checker.sv =====
// ----------------------------------------------------------------------------
// lora_time_on_air_checker: airtime predictor and result scoreboard
// Watches the req and rsp channels, computes the expected airtime record for
// each accepted query and compares every rsp beat with the oldest one queued.
// ----------------------------------------------------------------------------
module lora_time_on_air_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [lota_pkg::SF_W-1:0]     req_spreading_factor,
   input  logic [lota_pkg::BW_W-1:0]     req_bandwidth_hz,
   input  logic [lota_pkg::CR_W-1:0]     req_code_rate,
   input  logic [lota_pkg::MODE_W-1:0]   req_ldro_mode,
   input  logic [lota_pkg::MODE_W-1:0]   req_fine_sync_mode,
   input  logic [lota_pkg::MODE_W-1:0]   req_interleave_mode,
   input  logic [lota_pkg::PRE_W-1:0]    req_preamble_symbols,
   input  logic                          req_explicit_header,
   input  logic                          req_crc_present,
   input  logic [lota_pkg::PAY_W-1:0]    req_payload_bytes,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [lota_pkg::AIR_W-1:0]    rsp_airtime_us,
   input  logic [lota_pkg::QTR_W-1:0]    rsp_total_quarter_symbols,
   input  logic                          rsp_ldro_used,
   input  logic                          rsp_fine_sync_used,
   input  logic                          rsp_interleave_used,
   input  logic                          rsp_invalid,
   output int                            error_count,
   output int                            pending_count
);
   import lota_pkg::*;

   typedef struct packed {
      logic [AIR_W-1:0] airtime;
      logic [QTR_W-1:0] quarters;
      logic             ldro;
      logic             fs;
      logic             li;
      logic             invalid;
   } airtime_rec_type;

   airtime_rec_type expected_airtimes[$];

   function automatic longint ceil_div(longint a, longint b);
      if (a >= 0) return (a + b - 1) / b;
      return -((-a) / b);
   endfunction

   function automatic airtime_rec_type predict_airtime(
         logic [SF_W-1:0] sf, logic [BW_W-1:0] bw, logic [CR_W-1:0] cr,
         logic [MODE_W-1:0] lm, logic [MODE_W-1:0] fm, logic [MODE_W-1:0] im,
         logic [PRE_W-1:0] pre, logic hdr, logic crc, logic [PAY_W-1:0] pl);
      airtime_rec_type r;
      longint fs, li, ldro, nbytes, hbits, bps, d, data, pbits, st, start;
      longint unsigned qtr, num, air;
      r = '0;
      if (sf < SF_MIN || sf > SF_MAX || bw == 0 || bw > BW_MAX_HZ || cr == 0 ||
          lm == MODE_BAD || fm == MODE_BAD || im == MODE_BAD) begin
         r.invalid = 1'b1;
         return r;
      end
      fs   = (fm == MODE_AUTO) ? longint'(sf <= SF_FS_ON) : longint'(fm);
      li   = (im == MODE_AUTO) ? longint'(cr >= CR_LI_MIN) : longint'(im);
      ldro = (lm == MODE_AUTO) ? longint'(sf >= SF_LDRO_ON) : longint'(lm);
      nbytes = pl + 2 * crc;
      hbits  = 4 * sf + 8 * fs - 8 - (hdr ? 20 : 0);
      bps    = sf - 2 * ldro;
      d      = cr + (cr == CR_MAX ? 1 : 0);
      if (li == 0) begin
         pbits = 8 * nbytes - hbits;
         if (pbits < 0) pbits = 0;
         data = 8 + ceil_div(pbits, 4 * bps) * (cr + 4);
      end else if (hdr) begin
         if (hbits < 8 * nbytes && hbits > 8 * longint'(pl)) hbits = 8 * pl;
         pbits = 8 * nbytes - hbits;
         if (pbits < 0) pbits = 0;
         data = 8 + ceil_div(pbits * d, 4 * bps);
      end else begin
         st    = sf - 2 + 2 * fs;
         start = ceil_div(2 * nbytes * d, st);
         if (start < 8) data = start;
         else data = 8 + ceil_div(2 * nbytes * d - 8 * st, bps);
      end
      qtr = 4 * longint'(pre) + 17 + 8 * fs + 4 * data;
      num = (qtr << sf) * 250000;
      air = (num + bw / 2) / bw;
      r.airtime  = air[AIR_W-1:0];
      r.quarters = qtr[QTR_W-1:0];
      r.ldro = ldro[0];
      r.fs   = fs[0];
      r.li   = li[0];
      return r;
   endfunction

   assign pending_count = expected_airtimes.size();

   always @(posedge clock) begin
      airtime_rec_type want, got;
      if (reset) begin
         expected_airtimes.delete();
         error_count <= 0;
      end else begin
         if (req_valid && req_ready)
            expected_airtimes.push_back(predict_airtime(req_spreading_factor,
               req_bandwidth_hz, req_code_rate, req_ldro_mode, req_fine_sync_mode,
               req_interleave_mode, req_preamble_symbols, req_explicit_header,
               req_crc_present, req_payload_bytes));
         if (rsp_valid && rsp_ready) begin
            got = {rsp_airtime_us, rsp_total_quarter_symbols, rsp_ldro_used,
                   rsp_fine_sync_used, rsp_interleave_used, rsp_invalid};
            if (expected_airtimes.size() == 0) begin
               $display("%0t: rsp beat with nothing expected, got %h", $time, got);
               error_count <= error_count + 1;
            end else begin
               want = expected_airtimes.pop_front();
               if (want != got) begin
                  $display("%0t: mismatch expected air=%0d qtr=%0d l/f/i/inv=%b%b%b%b",
                     $time, want.airtime, want.quarters, want.ldro, want.fs,
                     want.li, want.invalid);
                  $display("%0t:          actual   air=%0d qtr=%0d l/f/i/inv=%b%b%b%b",
                     $time, got.airtime, got.quarters, got.ldro, got.fs,
                     got.li, got.invalid);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end

endmodule

// ===== tb/lora_time_on_air_core_tb.sv =====
// ----------------------------------------------------------------------------
// lora_time_on_air_core_tb: stimulus and verdict for the airtime core
// Drives directed corner queries, then random ones with bursty idling on both
// sides, a long receiver hold-off and a full drain; the checker compares.
// ----------------------------------------------------------------------------
module lora_time_on_air_core_tb;
   import lota_pkg::*;

   localparam int NUM_RANDOM   = 800;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 100;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [SF_W-1:0]     req_spreading_factor = '0;
   logic [BW_W-1:0]     req_bandwidth_hz = '0;
   logic [CR_W-1:0]     req_code_rate = '0;
   logic [MODE_W-1:0]   req_ldro_mode = '0;
   logic [MODE_W-1:0]   req_fine_sync_mode = '0;
   logic [MODE_W-1:0]   req_interleave_mode = '0;
   logic [PRE_W-1:0]    req_preamble_symbols = '0;
   logic                req_explicit_header = 1'b0;
   logic                req_crc_present = 1'b0;
   logic [PAY_W-1:0]    req_payload_bytes = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [AIR_W-1:0]    rsp_airtime_us;
   logic [QTR_W-1:0]    rsp_total_quarter_symbols;
   logic                rsp_ldro_used, rsp_fine_sync_used, rsp_interleave_used;
   logic                rsp_invalid;
   int                  error_count, pending_count;
   int                  cycle_count = 0;
   bit                  hold_off = 0;
   bit                  calm = 0;

   always #10 clock = ~clock;

   lora_time_on_air_core i_dut (.*);
   lora_time_on_air_checker i_checker (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // receiver: random stall bursts, a long hold-off on request
   initial begin
      int n;
      @(posedge clock iff !reset);
      forever begin
         if (hold_off) begin
            rsp_ready <= 1'b0;
            for (n = 0; n < 300; n++) @(posedge clock);
            hold_off = 0;
         end else if (!calm && $urandom_range(3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(16, 1)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(16, 1)) @(posedge clock);
         end
      end
   end

   task automatic send_query(logic [SF_W-1:0] sf, logic [BW_W-1:0] bw,
         logic [CR_W-1:0] cr, logic [MODE_W-1:0] lm, logic [MODE_W-1:0] fm,
         logic [MODE_W-1:0] im, logic [PRE_W-1:0] pre, logic hdr, logic crc,
         logic [PAY_W-1:0] pl);
      req_valid            <= 1'b1;
      req_spreading_factor <= sf;
      req_bandwidth_hz     <= bw;
      req_code_rate        <= cr;
      req_ldro_mode        <= lm;
      req_fine_sync_mode   <= fm;
      req_interleave_mode  <= im;
      req_preamble_symbols <= pre;
      req_explicit_header  <= hdr;
      req_crc_present      <= crc;
      req_payload_bytes    <= pl;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic pause_sender();
      if (!calm && $urandom_range(4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(16, 1)) @(posedge clock);
      end
   endtask

   task automatic send_random();
      logic [SF_W-1:0] sf;
      logic [BW_W-1:0] bw;
      logic [CR_W-1:0] cr;
      logic [MODE_W-1:0] lm, fm, im;
      logic [PRE_W-1:0] pre;
      sf  = ($urandom_range(19) == 0) ? SF_W'($urandom) : SF_W'($urandom_range(12, 5));
      case ($urandom_range(5))
         0:       bw = BW_W'($urandom);
         1:       bw = BW_W'($urandom_range(1625000, 1));
         2:       bw = BW_W'($urandom_range(1000, 1));
         default: bw = BW_W'(125000 << $urandom_range(3));
      endcase
      cr  = ($urandom_range(19) == 0) ? 3'd0 : CR_W'($urandom_range(7, 1));
      lm  = ($urandom_range(19) == 0) ? MODE_BAD : MODE_W'($urandom_range(2));
      fm  = ($urandom_range(19) == 0) ? MODE_BAD : MODE_W'($urandom_range(2));
      im  = ($urandom_range(19) == 0) ? MODE_BAD : MODE_W'($urandom_range(2));
      pre = ($urandom_range(3) == 0) ? PRE_W'($urandom) : PRE_W'($urandom_range(64));
      send_query(sf, bw, cr, lm, fm, im, pre, 1'($urandom), 1'($urandom),
                 PAY_W'($urandom));
   endtask

   initial begin
      int i, s, c;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: extremes, every mode and branch, invalid cases
      send_query(SF_MIN, 21'd1, 3'd1, MODE_OFF, MODE_OFF, MODE_OFF, 16'd0, 1'b0, 1'b0,
                 8'd0);
      send_query(SF_MAX, BW_MAX_HZ, CR_MAX, MODE_ON, MODE_ON, MODE_ON,
                 16'hFFFF, 1'b1, 1'b1, 8'hFF);
      send_query(SF_MAX, 21'd1, CR_MAX, MODE_ON, MODE_ON, MODE_OFF,
                 16'hFFFF, 1'b0, 1'b1, 8'hFF);
      for (s = 5; s <= 12; s++)
         for (c = 1; c <= 7; c += 3)
            send_query(SF_W'(s), 21'd125000, CR_W'(c), MODE_AUTO, MODE_AUTO,
                       MODE_AUTO, 16'd8, 1'(s), 1'(c), PAY_W'(s * 9));
      // forced interleave with small code rate, fixed length and header
      send_query(4'd7, 21'd250000, 3'd2, MODE_OFF, MODE_ON, MODE_ON, 16'd12, 1'b0, 1'b0,
                 8'd1);
      send_query(4'd9, 21'd500000, 3'd3, MODE_ON, MODE_OFF, MODE_ON, 16'd8, 1'b1, 1'b1,
                 8'd30);
      // invalid: sf low/high, bw zero/too big, cr zero, all three modes bad at once
      send_query(4'd4, 21'd125000, 3'd1, MODE_OFF, MODE_OFF, MODE_OFF, 16'd8, 1'b1, 1'b1,
                 8'd10);
      send_query(4'd15, 21'd125000, 3'd1, MODE_OFF, MODE_OFF, MODE_OFF, 16'd8, 1'b1, 1'b1,
                 8'd10);
      send_query(4'd7, 21'd0, 3'd1, MODE_OFF, MODE_OFF, MODE_OFF, 16'd8, 1'b1, 1'b1,
                 8'd10);
      send_query(4'd7, 21'h1FFFFF, 3'd1, MODE_OFF, MODE_OFF, MODE_OFF, 16'd8, 1'b1, 1'b1,
                 8'd10);
      send_query(4'd7, 21'd125000, 3'd0, MODE_OFF, MODE_OFF, MODE_OFF, 16'd8, 1'b1, 1'b1,
                 8'd10);
      send_query(4'd7, 21'd125000, 3'd1, MODE_BAD, MODE_BAD, MODE_BAD, 16'd8, 1'b1, 1'b1,
                 8'd10);
      for (i = 0; i < NUM_RANDOM; i++) begin
         if (i == 200) hold_off = 1;   // receiver stalls, pipeline backs up
         if (i == 400) begin
            req_valid <= 1'b0;
            while (pending_count != 0) @(posedge clock);
         end
         if (i == NUM_RANDOM - 100) calm = 1;
         pause_sender();
         send_random();
      end
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== lora_time_on_air_core.f =====
rtl/lota_pkg.sv
rtl/lota_div_cell.sv
rtl/lota_div_chain.sv
rtl/lota_front.sv
rtl/lota_time_on_air_core.sv
tb/lora_time_on_air_checker.sv
tb/lora_time_on_air_core_tb.sv
